// ----- src/itr_pkg.sv -----
// itr_pkg: shared constants, types and helpers for the integer-to-text block
// used by itr_front, itr_queue, itr_back and the top level
// no dependencies
package itr_pkg;

    // sizing
    localparam int MAX_DIGITS  = 32;
    localparam int VALUE_BITS  = 32;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int IN_VALUE_W  = 32;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W       = $clog2(MAX_DIGITS);
    localparam int BIT_W       = $clog2(VALUE_BITS);
    localparam int PFX_LVLS    = $clog2(MAX_DIGITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character and radix constants
    localparam logic [CHAR_W-1:0]  CHAR_ZERO          = 7'd48;
    localparam logic [CHAR_W-1:0]  CHAR_LETTER_A      = 7'd65;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS         = 7'd45;
    localparam logic [CHAR_W-1:0]  CHAR_NONE          = 7'd0;
    localparam logic [RADIX_W-1:0] DECIMAL            = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN          = 6'd2;
    localparam logic [RADIX_W-1:0] SIGNED_RADIX_MAX   = 6'd32;
    localparam logic [RADIX_W-1:0] UNSIGNED_RADIX_MAX = 6'd36;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [RADIX_W-1:0]    t_radix;
    typedef logic [RADIX_W-1:0]    t_digit;
    typedef logic [CHAR_W-1:0]     t_char;

    // one classified conversion job
    typedef struct packed {
        t_value mag;
        t_radix radix;
        logic   minus;
        logic   bad;
    } t_job;

    // head of the job queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_qhead;

    // digit value to ascii: 0..9 then capital letters
    function automatic t_char digit_to_char(input t_digit d);
        t_char c;
        if (d < DECIMAL) begin
            c = CHAR_ZERO + {1'b0, d};
        end else begin
            c = CHAR_LETTER_A + {1'b0, d} - {1'b0, DECIMAL};
        end
        return c;
    endfunction

endpackage

// ----- src/itr_queue.sv -----
// itr_queue: short job queue between the front end and the back end
// depends on itr_pkg
module itr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  itr_pkg::t_job    i_job,
    output logic             o_full,
    input  logic             i_pop,
    output itr_pkg::t_qhead  o_head
);

    itr_pkg::t_job                  r_mem [itr_pkg::QUEUE_DEPTH];
    logic [itr_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [itr_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [itr_pkg::QCNT_W-1:0]     r_count;
    logic [itr_pkg::QPTR_W-1:0]     n_wr_ptr;
    logic [itr_pkg::QPTR_W-1:0]     n_rd_ptr;
    logic [itr_pkg::QCNT_W-1:0]     n_count;

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            if (r_wr_ptr == itr_pkg::QPTR_W'(itr_pkg::QUEUE_DEPTH - 1)) begin
                n_wr_ptr = '0;
            end else begin
                n_wr_ptr = r_wr_ptr + 1'b1;
            end
        end
        if (i_pop) begin
            if (r_rd_ptr == itr_pkg::QPTR_W'(itr_pkg::QUEUE_DEPTH - 1)) begin
                n_rd_ptr = '0;
            end else begin
                n_rd_ptr = r_rd_ptr + 1'b1;
            end
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full       = (r_count == itr_pkg::QCNT_W'(itr_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.job   = r_mem[r_rd_ptr];

    // queue never over- or underflows
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != itr_pkg::QCNT_W'(itr_pkg::QUEUE_DEPTH)))
        else $error("queue pushed while full");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= itr_pkg::QCNT_W'(itr_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- src/itr_front.sv -----
// itr_front: accepts items, checks the radix, forms the magnitude and sign flag
// depends on itr_pkg; feeds itr_queue
module itr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [itr_pkg::IN_VALUE_W-1:0] i_value_in,
    input  logic                           i_is_signed,
    input  logic [itr_pkg::RADIX_W-1:0]    i_radix,
    input  logic                           i_q_full,
    output logic                           o_push,
    output itr_pkg::t_job                  o_job
);

    logic              r_vld;
    logic              n_vld;
    itr_pkg::t_job     r_job;
    itr_pkg::t_job     n_job;
    itr_pkg::t_value   v;
    itr_pkg::t_radix   hi;
    logic              neg;
    logic              accept;

    // classify the incoming item
    always_comb begin
        v   = itr_pkg::t_value'(i_value_in);
        neg = i_is_signed & v[itr_pkg::VALUE_BITS-1];
        hi  = i_is_signed ? itr_pkg::SIGNED_RADIX_MAX : itr_pkg::UNSIGNED_RADIX_MAX;
        n_job.mag   = neg ? itr_pkg::t_value'(~v + itr_pkg::t_value'(1)) : v;
        n_job.radix = i_radix;
        n_job.minus = neg && (i_radix == itr_pkg::DECIMAL);
        n_job.bad   = (i_radix < itr_pkg::RADIX_MIN) || (i_radix > hi);
    end

    // one holding stage ahead of the queue
    assign o_push = r_vld & ~i_q_full;
    assign o_busy = r_vld & i_q_full;
    assign accept = i_start & ~o_busy;
    assign n_vld  = accept | (r_vld & ~o_push);
    assign o_job  = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- src/itr_back.sv -----
// itr_back: radix conversion by bit-serial doubling into a digit register,
//   then emission of the characters most significant first
// depends on itr_pkg; reads jobs from itr_queue
module itr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  itr_pkg::t_qhead             i_head,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [itr_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                        o_last,
    output logic                        o_bad_radix
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    itr_pkg::t_value              r_val;
    itr_pkg::t_value              n_val;
    itr_pkg::t_radix              r_radix;
    itr_pkg::t_radix              n_radix;
    logic                         r_minus;
    logic                         n_minus;
    itr_pkg::t_digit              r_dig [itr_pkg::MAX_DIGITS];
    itr_pkg::t_digit              n_dig [itr_pkg::MAX_DIGITS];
    itr_pkg::t_digit              dbl_dig [itr_pkg::MAX_DIGITS];
    logic [itr_pkg::CNT_W-1:0]    r_ndig;
    logic [itr_pkg::CNT_W-1:0]    n_ndig;
    logic [itr_pkg::CNT_W-1:0]    grow_ndig;
    logic [itr_pkg::BIT_W-1:0]    r_bitcnt;
    logic [itr_pkg::BIT_W-1:0]    n_bitcnt;
    logic [itr_pkg::IDX_W-1:0]    r_idx;
    logic [itr_pkg::IDX_W-1:0]    n_idx;
    logic                         r_sign;
    logic                         n_sign;
    logic                         r_strobe;
    logic                         n_strobe;
    itr_pkg::t_char               r_char;
    itr_pkg::t_char               n_char;
    logic                         r_last;
    logic                         n_last;
    logic                         r_bad;
    logic                         n_bad;

    logic [itr_pkg::MAX_DIGITS-1:0] gen;
    logic [itr_pkg::MAX_DIGITS-1:0] prop;
    logic [itr_pkg::MAX_DIGITS-1:0] gg;
    logic [itr_pkg::MAX_DIGITS-1:0] pp;
    logic [itr_pkg::MAX_DIGITS-1:0] ng;
    logic [itr_pkg::MAX_DIGITS-1:0] np;
    logic [itr_pkg::MAX_DIGITS:0]   carry;
    logic [itr_pkg::RADIX_W:0]      rr;
    logic [itr_pkg::RADIX_W:0]      t2;
    logic                           cin;

    // doubling step: digits = 2 * digits + next value bit, carries by prefix tree
    always_comb begin
        rr  = {1'b0, r_radix};
        cin = r_val[itr_pkg::VALUE_BITS-1];
        for (int i = 0; i < itr_pkg::MAX_DIGITS; i++) begin
            gen[i]  = ({r_dig[i], 1'b0} >= rr);
            prop[i] = ({r_dig[i], 1'b1} == rr);
        end
        gg    = gen;
        pp    = prop;
        gg[0] = gen[0] | (prop[0] & cin);
        pp[0] = 1'b0;
        for (int lvl = 0; lvl < itr_pkg::PFX_LVLS; lvl++) begin
            for (int i = 0; i < itr_pkg::MAX_DIGITS; i++) begin
                if (i >= (1 << lvl)) begin
                    ng[i] = gg[i] | (pp[i] & gg[i - (1 << lvl)]);
                    np[i] = pp[i] & pp[i - (1 << lvl)];
                end else begin
                    ng[i] = gg[i];
                    np[i] = pp[i];
                end
            end
            gg = ng;
            pp = np;
        end
        carry[0] = cin;
        for (int i = 0; i < itr_pkg::MAX_DIGITS; i++) begin
            carry[i+1] = gg[i];
        end
        for (int i = 0; i < itr_pkg::MAX_DIGITS; i++) begin
            t2 = {r_dig[i], carry[i]};
            if (t2 >= rr) begin
                dbl_dig[i] = itr_pkg::RADIX_W'(t2 - rr);
            end else begin
                dbl_dig[i] = itr_pkg::RADIX_W'(t2);
            end
        end
        // a carry into the first unused digit extends the text by one
        if ((r_ndig < itr_pkg::CNT_W'(itr_pkg::MAX_DIGITS)) && carry[r_ndig]) begin
            grow_ndig = r_ndig + 1'b1;
        end else begin
            grow_ndig = r_ndig;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_radix  = r_radix;
        n_minus  = r_minus;
        n_dig    = r_dig;
        n_ndig   = r_ndig;
        n_bitcnt = r_bitcnt;
        n_idx    = r_idx;
        n_sign   = r_sign;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        n_bad    = r_bad;
        o_pop    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.job.bad) begin
                        n_strobe = 1'b1;
                        n_char   = itr_pkg::CHAR_NONE;
                        n_last   = 1'b1;
                        n_bad    = 1'b1;
                    end else begin
                        n_val    = i_head.job.mag;
                        n_radix  = i_head.job.radix;
                        n_minus  = i_head.job.minus;
                        n_ndig   = itr_pkg::CNT_W'(1);
                        n_bitcnt = '0;
                        for (int i = 0; i < itr_pkg::MAX_DIGITS; i++) begin
                            n_dig[i] = '0;
                        end
                        n_state  = S_CONV;
                    end
                end
            end
            S_CONV: begin
                n_dig    = dbl_dig;
                n_ndig   = grow_ndig;
                n_val    = r_val << 1;
                n_bitcnt = r_bitcnt + 1'b1;
                if (r_bitcnt == itr_pkg::BIT_W'(itr_pkg::VALUE_BITS - 1)) begin
                    n_state = S_EMIT;
                    n_idx   = itr_pkg::IDX_W'(grow_ndig - 1'b1);
                    n_sign  = r_minus && (grow_ndig < itr_pkg::CNT_W'(itr_pkg::MAX_DIGITS));
                end
            end
            S_EMIT: begin
                n_strobe = 1'b1;
                n_bad    = 1'b0;
                if (r_sign) begin
                    n_char = itr_pkg::CHAR_MINUS;
                    n_last = 1'b0;
                    n_sign = 1'b0;
                end else begin
                    n_char = itr_pkg::digit_to_char(r_dig[r_idx]);
                    n_last = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_ndig   <= itr_pkg::CNT_W'(1);
            r_sign   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_ndig   <= n_ndig;
            r_sign   <= n_sign;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_val    <= n_val;
        r_radix  <= n_radix;
        r_minus  <= n_minus;
        r_dig    <= n_dig;
        r_bitcnt <= n_bitcnt;
        r_idx    <= n_idx;
        r_char   <= n_char;
        r_last   <= n_last;
        r_bad    <= n_bad;
    end

    assign o_strobe     = r_strobe;
    assign o_digit_char = r_char;
    assign o_last       = r_strobe & r_last;
    assign o_bad_radix  = r_strobe & r_bad;

    // checks on conversion and emission
    a_ndig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ndig != '0) && (r_ndig <= itr_pkg::CNT_W'(itr_pkg::MAX_DIGITS)))
        else $error("digit count out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && i_head.valid)
        else $error("job taken outside idle");
    a_bad_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bad_radix |-> o_last && (o_digit_char == itr_pkg::CHAR_NONE))
        else $error("bad radix result malformed");
    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> o_strobe)
        else $error("emit cycle without strobe");

endmodule

// ----- src/integer_to_text_any_radix.sv -----
// integer_to_text_any_radix: top level of the integer-to-text converter
// depends on itr_pkg, itr_front, itr_queue, itr_back
//
// Usage
//   Input: an item (i_value_in, i_is_signed, i_radix) is taken at a rising
//   edge where start is high and busy is low. busy rises only when the
//   holding stage and the two-entry job queue are all full.
//   Output: characters come out most significant first, one per cycle,
//   each marked by o_strobe for exactly one cycle; o_last flags the final
//   character. A radix outside 2..32 (signed) or 2..36 (unsigned) gives a
//   single result with o_digit_char 0, o_last and o_bad_radix set.
//   Flow: a job leaves the queue, then the digit register doubles in
//   all VALUE_BITS (32) value bits, one value bit per cycle, then the
//   characters are emitted, one per cycle. A bad radix job is taken in
//   idle and its result follows in the next cycle. The back end sets the
//   rate, converting then emitting each item before it takes the next;
//   the front end and queue overlap item intake with it.
//   Reset: synchronous, active low; clears the queue and all control
//   state, no result is in flight afterward. The receiver cannot stall:
//   every strobed result must be taken in its cycle.
module integer_to_text_any_radix (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [itr_pkg::IN_VALUE_W-1:0] i_value_in,
    input  logic                           i_is_signed,
    input  logic [itr_pkg::RADIX_W-1:0]    i_radix,
    output logic                           o_strobe,
    output logic [itr_pkg::CHAR_W-1:0]     o_digit_char,
    output logic                           o_last,
    output logic                           o_bad_radix
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    itr_pkg::t_job    f_job;
    itr_pkg::t_qhead  q_head;

    // item intake and classification
    itr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_value_in  (i_value_in),
        .i_is_signed (i_is_signed),
        .i_radix     (i_radix),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (f_job)
    );

    // job queue
    itr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // conversion and character output
    itr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_radix  (o_bad_radix)
    );

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for integer_to_text_any_radix
// drives directed then random conversions with random gaps and checks every character
// depends on itr_pkg and the integer_to_text_any_radix top level
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned RANDOM_ITEMS = 236;

    // one conversion request
    typedef struct {
        itr_pkg::t_value value;
        logic            sgn;
        itr_pkg::t_radix rdx;
    } t_request;

    // one character of expected text
    typedef struct {
        itr_pkg::t_char ch;
        logic           last;
        logic           bad;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [itr_pkg::IN_VALUE_W-1:0] i_value_in = '0;
    logic i_is_signed = 1'b0;
    itr_pkg::t_radix i_radix = '0;
    logic o_strobe;
    itr_pkg::t_char o_digit_char;
    logic o_last;
    logic o_bad_radix;

    t_request   pending_items[$];
    t_text_char text_expected[$];
    t_request   req_next;
    t_text_char exp_ch;

    int unsigned total_items = 0;
    int unsigned items_taken = 0;
    int unsigned chars_seen = 0;
    int unsigned bad_seen = 0;
    int unsigned minus_seen = 0;
    int unsigned errors = 0;
    int unsigned gap_left = 0;
    int unsigned calm_left = 0;

    integer_to_text_any_radix u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value_in   (i_value_in),
        .i_is_signed  (i_is_signed),
        .i_radix      (i_radix),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_bad_radix  (o_bad_radix)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // expected text for one item, most significant character first
    task automatic predict_text(input itr_pkg::t_value v, input logic sgn,
                                input itr_pkg::t_radix rdx);
        itr_pkg::t_char  digs[$];
        itr_pkg::t_value mag;
        itr_pkg::t_digit d;
        itr_pkg::t_radix top_rdx;
        logic            neg;
        t_text_char      tc;
        top_rdx = sgn ? itr_pkg::SIGNED_RADIX_MAX : itr_pkg::UNSIGNED_RADIX_MAX;
        if (rdx < itr_pkg::RADIX_MIN || rdx > top_rdx) begin
            tc.ch = itr_pkg::CHAR_NONE;
            tc.last = 1'b1;
            tc.bad = 1'b1;
            text_expected.push_back(tc);
            return;
        end
        neg = sgn && v[itr_pkg::VALUE_BITS-1];
        mag = neg ? (~v + 1'b1) : v;
        do begin
            d = itr_pkg::t_digit'(mag % rdx);
            if (d < itr_pkg::DECIMAL) begin
                digs.push_front(itr_pkg::CHAR_ZERO + itr_pkg::t_char'(d));
            end else begin
                digs.push_front(itr_pkg::CHAR_LETTER_A + itr_pkg::t_char'(d)
                                - itr_pkg::t_char'(itr_pkg::DECIMAL));
            end
            mag = mag / rdx;
        end while (mag != 0);
        if (neg && rdx == itr_pkg::DECIMAL) begin
            digs.push_front(itr_pkg::CHAR_MINUS);
        end
        // leading characters are dropped when the text is too long
        while (digs.size() > itr_pkg::MAX_DIGITS) begin
            void'(digs.pop_front());
        end
        foreach (digs[k]) begin
            tc.ch = digs[k];
            tc.last = (k == digs.size() - 1);
            tc.bad = 1'b0;
            text_expected.push_back(tc);
        end
    endtask

    // idle length between items: mostly none or short, a few long, some calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 90);
    endfunction

    task automatic add_item(input itr_pkg::t_value v, input logic sgn,
                            input itr_pkg::t_radix rdx);
        t_request req;
        req.value = v;
        req.sgn = sgn;
        req.rdx = rdx;
        pending_items.push_back(req);
    endtask

    // value picked to exercise digit boundaries of the radix
    function automatic itr_pkg::t_value pick_value(input itr_pkg::t_radix rdx);
        logic [63:0] p;
        int unsigned k;
        case ($urandom_range(0, 5))
            0, 1: return $urandom();
            2: return $urandom_range(0, 1000);
            3: begin
                p = 64'd1;
                k = $urandom_range(1, 32);
                if (rdx >= itr_pkg::RADIX_MIN) begin
                    repeat (k) begin
                        if (p * rdx <= 64'hFFFF_FFFF) p = p * rdx;
                    end
                end
                return itr_pkg::t_value'(p[31:0] + $urandom_range(0, 2) - 1);
            end
            4: begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h8000_0000;
                    4: return 32'h8000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return itr_pkg::t_value'(0 - $urandom_range(1, 1000));
        endcase
    endfunction

    // driver: launches queued items, predicts each one as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            // hold the item until the block takes it
        end else begin
            if (start) begin
                predict_text(i_value_in, i_is_signed, i_radix);
                items_taken++;
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                req_next = pending_items.pop_front();
                i_value_in <= req_next.value;
                i_is_signed <= req_next.sgn;
                i_radix <= req_next.rdx;
                start <= 1'b1;
                gap_left = pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobed character against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            chars_seen++;
            if (o_bad_radix) bad_seen++;
            if (o_digit_char == itr_pkg::CHAR_MINUS) minus_seen++;
            if (text_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected character: expected none, got %0d last %0b bad %0b",
                         $time, o_digit_char, o_last, o_bad_radix);
            end else begin
                exp_ch = text_expected.pop_front();
                if (o_digit_char !== exp_ch.ch) begin
                    errors++;
                    $display("%0t: digit_char mismatch: expected %0d, got %0d",
                             $time, exp_ch.ch, o_digit_char);
                end
                if (o_last !== exp_ch.last) begin
                    errors++;
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, exp_ch.last, o_last);
                end
                if (o_bad_radix !== exp_ch.bad) begin
                    errors++;
                    $display("%0t: bad_radix mismatch: expected %0b, got %0b",
                             $time, exp_ch.bad, o_bad_radix);
                end
            end
        end
    end

    // timeout guard
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d of %0d items taken, %0d characters pending",
                 CYCLE_LIMIT, items_taken, total_items, text_expected.size());
        $display("Test completed with failures");
        $finish;
    end

    // stimulus and end of run
    initial begin
        logic            sgn;
        itr_pkg::t_radix rdx;

        // directed: zero, extremes, most negative value, sign rules, radix limits
        add_item(32'd0, 1'b0, itr_pkg::DECIMAL);
        add_item(32'd0, 1'b1, itr_pkg::RADIX_MIN);
        add_item(32'hFFFF_FFFF, 1'b0, itr_pkg::RADIX_MIN);
        add_item(32'hFFFF_FFFF, 1'b0, itr_pkg::UNSIGNED_RADIX_MAX);
        add_item(32'hFFFF_FFFF, 1'b0, 6'd35);
        add_item(32'hFFFF_FFFF, 1'b1, itr_pkg::DECIMAL);
        add_item(32'h8000_0000, 1'b1, itr_pkg::DECIMAL);
        add_item(32'h8000_0000, 1'b1, 6'd16);
        add_item(32'h8000_0000, 1'b1, itr_pkg::RADIX_MIN);
        add_item(32'h8000_0000, 1'b0, itr_pkg::DECIMAL);
        add_item(32'h7FFF_FFFF, 1'b1, itr_pkg::SIGNED_RADIX_MAX);
        add_item(32'h7FFF_FFFF, 1'b1, itr_pkg::DECIMAL);
        add_item(32'hFFFF_FF85, 1'b1, 6'd7);
        add_item(32'hFFFF_FFF6, 1'b1, itr_pkg::RADIX_MIN);
        add_item(32'd12345, 1'b1, itr_pkg::DECIMAL);
        add_item(32'd1295, 1'b0, itr_pkg::UNSIGNED_RADIX_MAX);
        add_item(32'd1, 1'b0, 6'd0);
        add_item(32'd1, 1'b0, 6'd1);
        add_item(32'd1, 1'b0, 6'd37);
        add_item(32'd1, 1'b0, 6'd63);
        add_item(32'hFFFF_FFFF, 1'b1, 6'd33);
        add_item(32'd5, 1'b1, itr_pkg::UNSIGNED_RADIX_MAX);
        add_item(32'd5, 1'b1, 6'd1);
        add_item(32'hDEAD_BEEF, 1'b1, 6'd63);

        // random: mostly valid radixes with boundary-heavy values, some of any radix
        repeat (RANDOM_ITEMS) begin
            sgn = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 8) begin
                rdx = sgn ? itr_pkg::t_radix'($urandom_range(itr_pkg::RADIX_MIN,
                                                             itr_pkg::SIGNED_RADIX_MAX))
                          : itr_pkg::t_radix'($urandom_range(itr_pkg::RADIX_MIN,
                                                             itr_pkg::UNSIGNED_RADIX_MAX));
            end else begin
                rdx = itr_pkg::t_radix'($urandom_range(0, 63));
            end
            add_item(pick_value(rdx), sgn, rdx);
        end
        total_items = pending_items.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken < total_items) @(posedge i_clk);
        while (text_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (text_expected.size() != 0) begin
            errors++;
            $display("%0t: %0d expected characters never arrived", $time, text_expected.size());
        end
        $display("converted %0d items (signed and unsigned, radix 0..63) into %0d characters",
                 items_taken, chars_seen);
        $display("bad radix results: %0d, minus signs: %0d, errors: %0d",
                 bad_seen, minus_seen, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/itr_pkg.sv
src/itr_queue.sv
src/itr_front.sv
src/itr_back.sv
src/integer_to_text_any_radix.sv
sim/tb_top.sv
